// ===== hdl/arm_forward_kinematics_defines.svh =====
// Assertion macros shared by the arm forward kinematics RTL.
// Expects signals clk and arst_n in the scope of each use.
`ifndef ARM_FORWARD_KINEMATICS_DEFINES_SVH
`define ARM_FORWARD_KINEMATICS_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define AFK_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define AFK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/afk_pkg.sv =====
// Shared types, constants and functions of the arm forward kinematics block.
// No dependencies; used by every module under hdl.
`default_nettype none
package afk_pkg;

	localparam int CORDIC_STAGES = 24;

	// Field and datapath widths
	localparam int ENC_W  = 24;
	localparam int ANG_W  = 31;
	localparam int MOD_W  = 57;
	localparam int MOD_STEPS = 27;
	localparam int XY_W   = 33;
	localparam int Z_W    = 32;
	localparam int LEN_W  = 16;
	localparam int TERM_W = 20;
	localparam int ACC_W  = 22;
	localparam int POS_W  = 19;

	// Angle constants, Q4.28 radians
	localparam logic [ANG_W-1:0] ANG_2PI = 31'd1686629713;
	localparam logic [ANG_W-1:0] ANG_PI  = 31'd843314857;
	localparam logic signed [Z_W-1:0] ANG_2PI_S    = 32'sd1686629713;
	localparam logic signed [Z_W-1:0] ANG_PI_S     = 32'sd843314857;
	localparam logic signed [Z_W-1:0] ANG_HALF_PI_S = 32'sd421657428;
	localparam logic signed [XY_W-1:0] CORDIC_K    = 33'sd652032874;

	// Bias that makes count*gain+offset non-negative (2pi * 2^25)
	localparam logic [MOD_W-1:0] MOD_BIAS = 57'(ANG_2PI) << 25;

	localparam logic signed [ACC_W-1:0] POS_MAX = 22'sd262143;
	localparam logic signed [ACC_W-1:0] POS_MIN = -22'sd262144;

	// Pipeline stage positions in the valid chain
	localparam int ST_ENC      = 0;
	localparam int ST_MUL      = 1;
	localparam int ST_MOD_LAST = ST_MUL + MOD_STEPS;
	localparam int ST_P1       = ST_MOD_LAST + 1;
	localparam int ST_P2       = ST_P1 + 1;
	localparam int ST_PRE      = ST_P2 + 1;
	localparam int ST_SEG_C    = ST_PRE + CORDIC_STAGES + 3;
	localparam int ST_ACC      = ST_SEG_C + 1;
	localparam int NUM_ST      = ST_ACC + 1;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_BASE_MAP     = 3'd0,
		CFG_SHOULDER_MAP = 3'd1,
		CFG_ELBOW_MAP    = 3'd2,
		CFG_WRIST_MAP    = 3'd3,
		CFG_BASE_HEIGHT  = 3'd4,
		CFG_UPPER_LEN    = 3'd5,
		CFG_FOREARM_LEN  = 3'd6,
		CFG_HAND_LEN     = 3'd7
	} cfg_idx_t;

	// One CORDIC lane as it moves from cell to cell
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   neg;
	} cordic_t;

	// atan(2^-i) in Q28, rounded
	function automatic logic signed [Z_W-1:0] atan_q28(input logic [4:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			5'd0:  r = 32'sd210828714;
			5'd1:  r = 32'sd124459457;
			5'd2:  r = 32'sd65760959;
			5'd3:  r = 32'sd33381290;
			5'd4:  r = 32'sd16755422;
			5'd5:  r = 32'sd8385879;
			5'd6:  r = 32'sd4193963;
			5'd7:  r = 32'sd2097109;
			5'd8:  r = 32'sd1048571;
			5'd9:  r = 32'sd524287;
			5'd10: r = 32'sd262144;
			5'd11: r = 32'sd131072;
			5'd12: r = 32'sd65536;
			5'd13: r = 32'sd32768;
			5'd14: r = 32'sd16384;
			5'd15: r = 32'sd8192;
			5'd16: r = 32'sd4096;
			5'd17: r = 32'sd2048;
			5'd18: r = 32'sd1024;
			5'd19: r = 32'sd512;
			5'd20: r = 32'sd256;
			5'd21: r = 32'sd128;
			5'd22: r = 32'sd64;
			5'd23: r = 32'sd32;
			5'd24: r = 32'sd16;
			5'd25: r = 32'sd8;
			5'd26: r = 32'sd4;
			5'd27: r = 32'sd2;
			5'd28: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// Clamp a position to the 19-bit output range
	function automatic logic [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		c = v;
		if (v > POS_MAX) c = POS_MAX;
		if (v < POS_MIN) c = POS_MIN;
		return c[POS_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/afk_mod_cell.sv =====
// One restoring step of the modulo-2pi reduction chain.
// Depends on afk_pkg.
`default_nettype none
module afk_mod_cell (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [afk_pkg::MOD_W-1:0]  sub,
	input  wire logic [afk_pkg::MOD_W-1:0]  din,
	output logic      [afk_pkg::MOD_W-1:0]  dout
);

	logic [afk_pkg::MOD_W-1:0] val_q;

	// Subtract the scaled modulus when it fits, then hand on
	always_ff @(posedge clk) begin
		if (en) begin
			val_q <= (din >= sub) ? din - sub : din;
		end
	end

	assign dout = val_q;

endmodule
`default_nettype wire

// ===== hdl/afk_cordic_cell.sv =====
// One rotation iteration of the CORDIC chain.
// Depends on afk_pkg (cordic_t, widths).
`default_nettype none
module afk_cordic_cell (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [4:0]                    shift,
	input  wire logic signed [afk_pkg::Z_W-1:0] atan,
	input  wire afk_pkg::cordic_t              din,
	output afk_pkg::cordic_t                   dout
);

	afk_pkg::cordic_t        cell_q;
	logic signed [afk_pkg::XY_W-1:0] dx;
	logic signed [afk_pkg::XY_W-1:0] dy;

	assign dx = din.y >>> shift;
	assign dy = din.x >>> shift;

	// Rotate toward zero residual angle
	always_ff @(posedge clk) begin
		if (en) begin
			cell_q.neg <= din.neg;
			if (!din.z[afk_pkg::Z_W-1]) begin
				cell_q.x <= din.x - dx;
				cell_q.y <= din.y + dy;
				cell_q.z <= din.z - atan;
			end else begin
				cell_q.x <= din.x + dx;
				cell_q.y <= din.y - dy;
				cell_q.z <= din.z + atan;
			end
		end
	end

	assign dout = cell_q;

endmodule
`default_nettype wire

// ===== hdl/afk_segment.sv =====
// Projects one arm segment onto x, y and z over three pipeline stages.
// Depends on afk_pkg (widths).
`default_nettype none
module afk_segment (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [afk_pkg::LEN_W-1:0]         len,
	input  wire logic signed [afk_pkg::XY_W-1:0]   cp,
	input  wire logic signed [afk_pkg::XY_W-1:0]   sp,
	input  wire logic signed [afk_pkg::XY_W-1:0]   cy,
	input  wire logic signed [afk_pkg::XY_W-1:0]   sy,
	output logic signed [afk_pkg::TERM_W-1:0]      tx,
	output logic signed [afk_pkg::TERM_W-1:0]      ty,
	output logic signed [afk_pkg::TERM_W-1:0]      tz
);

	logic signed [49:0] lc;
	logic signed [49:0] ls;
	logic signed [49:0] lsr;
	logic signed [33:0] h_s1;
	logic signed [afk_pkg::TERM_W-1:0] vz_s1;
	logic signed [afk_pkg::XY_W-1:0] cy_s1;
	logic signed [afk_pkg::XY_W-1:0] sy_s1;
	logic signed [66:0] px_s2;
	logic signed [66:0] py_s2;
	logic signed [afk_pkg::TERM_W-1:0] vz_s2;
	logic signed [66:0] rx;
	logic signed [67:0] ry;
	logic signed [afk_pkg::TERM_W-1:0] tx_s3;
	logic signed [afk_pkg::TERM_W-1:0] ty_s3;
	logic signed [afk_pkg::TERM_W-1:0] tz_s3;

	assign lc  = $signed({1'b0, len}) * cp;
	assign ls  = $signed({1'b0, len}) * sp;
	assign lsr = (ls + 50'sh20000000) >>> 30;

	// Horizontal reach and rounded vertical term
	always_ff @(posedge clk) begin
		if (en) begin
			h_s1  <= 34'(lc >>> 16);
			vz_s1 <= afk_pkg::TERM_W'(lsr);
			cy_s1 <= cy;
			sy_s1 <= sy;
		end
	end

	// Rotate the reach by the base yaw
	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= h_s1 * cy_s1;
			py_s2 <= h_s1 * sy_s1;
			vz_s2 <= vz_s1;
		end
	end

	assign rx = (px_s2 + 67'sh80000000000) >>> 44;
	assign ry = (-$signed({py_s2[66], py_s2}) + 68'sh80000000000) >>> 44;

	// Round the horizontal terms
	always_ff @(posedge clk) begin
		if (en) begin
			tx_s3 <= afk_pkg::TERM_W'(rx);
			ty_s3 <= afk_pkg::TERM_W'(ry);
			tz_s3 <= vz_s2;
		end
	end

	assign tx = tx_s3;
	assign ty = ty_s3;
	assign tz = tz_s3;

endmodule
`default_nettype wire

// ===== hdl/arm_forward_kinematics.sv =====
// Top level of the four-joint arm forward kinematics pipeline.
// Depends on afk_pkg, afk_mod_cell, afk_cordic_cell, afk_segment and the defines header.
//
// channel | direction | ports                          | content
// --------+-----------+--------------------------------+-------------------------------
// s_      | in        | s_tvalid s_tready s_tdata[95:0] | four joint encoder counts
// m_      | out       | m_tvalid m_tready m_tdata[175:0]| elbow, wrist, tip xyz
// cfg_    | in        | cfg_we cfg_addr cfg_wdata       | angle maps and segment lengths
//
// One pose per cycle unless the output stalls; each pose passes the input and raw registers,
// 27 modulo cells, pitch and seed registers, the CORDIC chain, three segment stages and output.
// Reset clears valid bits and the configuration registers to zero.
// The pipeline holds only while its last stage and the output register are both full
// and m_tready is low.
`default_nettype none
`include "arm_forward_kinematics_defines.svh"
module arm_forward_kinematics (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [95:0]  s_tdata,   // base, shoulder, elbow, wrist encoder (24 bits each)
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [175:0]      m_tdata,   // elbow x,y,z, wrist x,y,z, tip x,y,z (19 bits), 5 pad
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_addr,
	input  wire logic [63:0]  cfg_wdata
);

	localparam int CS = afk_pkg::CORDIC_STAGES;

	logic [63:0] map_q [0:3];
	logic [afk_pkg::LEN_W-1:0] len_q [0:3];
	logic [afk_pkg::NUM_ST-1:0] vld_q;
	logic en;

	logic [afk_pkg::ENC_W-1:0] enc_s1 [0:3];
	logic [afk_pkg::MOD_W-1:0] mod_chain [0:afk_pkg::MOD_STEPS][0:3];
	logic [afk_pkg::ANG_W-1:0] ang [0:3];
	logic [afk_pkg::ANG_W-1:0] pa_s3 [0:3];
	logic [afk_pkg::ANG_W-1:0] pa_s4 [0:3];
	logic [afk_pkg::ANG_W:0] sum12;
	logic [afk_pkg::ANG_W:0] sum23;
	afk_pkg::cordic_t cor [0:CS][0:3];
	logic signed [afk_pkg::XY_W-1:0] cosv [0:3];
	logic signed [afk_pkg::XY_W-1:0] sinv [0:3];
	logic signed [afk_pkg::TERM_W-1:0] tx [0:2];
	logic signed [afk_pkg::TERM_W-1:0] ty [0:2];
	logic signed [afk_pkg::TERM_W-1:0] tz [0:2];
	logic signed [afk_pkg::ACC_W-1:0] px_s5 [0:2];
	logic signed [afk_pkg::ACC_W-1:0] py_s5 [0:2];
	logic signed [afk_pkg::ACC_W-1:0] pz_s5 [0:2];
	logic signed [afk_pkg::ACC_W-1:0] zb;
	logic m_valid_q;
	logic [175:0] m_data_q;
	logic ang_in_range;
	logic seed_in_range;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				map_q[i] <= '0;
				len_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (afk_pkg::cfg_idx_t'(cfg_addr))
				afk_pkg::CFG_BASE_MAP:     map_q[0] <= cfg_wdata;
				afk_pkg::CFG_SHOULDER_MAP: map_q[1] <= cfg_wdata;
				afk_pkg::CFG_ELBOW_MAP:    map_q[2] <= cfg_wdata;
				afk_pkg::CFG_WRIST_MAP:    map_q[3] <= cfg_wdata;
				afk_pkg::CFG_BASE_HEIGHT:  len_q[0] <= cfg_wdata[afk_pkg::LEN_W-1:0];
				afk_pkg::CFG_UPPER_LEN:    len_q[1] <= cfg_wdata[afk_pkg::LEN_W-1:0];
				afk_pkg::CFG_FOREARM_LEN:  len_q[2] <= cfg_wdata[afk_pkg::LEN_W-1:0];
				afk_pkg::CFG_HAND_LEN:     len_q[3] <= cfg_wdata[afk_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance unless the last stage and the output register are both blocked
	assign en       = !vld_q[afk_pkg::ST_ACC] || !m_valid_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[afk_pkg::NUM_ST-2:0], s_tvalid};
		end
	end

	// Capture encoder counts on transfer
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				enc_s1[j] <= s_tdata[j*afk_pkg::ENC_W +: afk_pkg::ENC_W];
			end
		end
	end

	// Raw angle count*gain+offset, biased non-negative
	generate
		for (genvar j = 0; j < 4; j++) begin : g_raw
			logic signed [afk_pkg::MOD_W-1:0] raw;
			logic [afk_pkg::MOD_W-1:0] u_s2;
			assign raw = $signed(enc_s1[j]) * $signed(map_q[j][63:32])
				+ $signed(map_q[j][31:0]);
			always_ff @(posedge clk) begin
				if (en) begin
					u_s2 <= afk_pkg::MOD_W'(raw) + afk_pkg::MOD_BIAS;
				end
			end
			assign mod_chain[0][j] = u_s2;
		end
	endgenerate

	// Modulo-2pi reduction, one scaled modulus per cell
	generate
		for (genvar k = 0; k < afk_pkg::MOD_STEPS; k++) begin : g_mod
			for (genvar j = 0; j < 4; j++) begin : g_lane
				afk_mod_cell u_cell (
					.clk  (clk),
					.en   (en),
					.sub  (afk_pkg::MOD_W'(afk_pkg::ANG_2PI) << (afk_pkg::MOD_STEPS - 1 - k)),
					.din  (mod_chain[k][j]),
					.dout (mod_chain[k+1][j])
				);
			end
		end
		for (genvar j = 0; j < 4; j++) begin : g_ang
			assign ang[j] = mod_chain[afk_pkg::MOD_STEPS][j][afk_pkg::ANG_W-1:0];
		end
	endgenerate

	// Pitch sums, wrapped into [0, 2pi)
	assign sum12 = {1'b0, ang[1]} + {1'b0, ang[2]};
	assign sum23 = {1'b0, pa_s3[2]} + {1'b0, pa_s3[3]};

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s3[0] <= ang[0];
			pa_s3[1] <= ang[1];
			pa_s3[2] <= (sum12 >= {1'b0, afk_pkg::ANG_2PI}) ?
				afk_pkg::ANG_W'(sum12 - {1'b0, afk_pkg::ANG_2PI}) : afk_pkg::ANG_W'(sum12);
			pa_s3[3] <= ang[3];
			pa_s4[0] <= pa_s3[0];
			pa_s4[1] <= pa_s3[1];
			pa_s4[2] <= pa_s3[2];
			pa_s4[3] <= (sum23 >= {1'b0, afk_pkg::ANG_2PI}) ?
				afk_pkg::ANG_W'(sum23 - {1'b0, afk_pkg::ANG_2PI}) : afk_pkg::ANG_W'(sum23);
		end
	end

	// Fold each angle into [-pi/2, pi/2] and seed the CORDIC lanes
	generate
		for (genvar j = 0; j < 4; j++) begin : g_pre
			logic signed [afk_pkg::Z_W-1:0] a0;
			logic signed [afk_pkg::Z_W-1:0] a1;
			logic nf;
			afk_pkg::cordic_t pre_q;
			always_comb begin
				a0 = $signed({1'b0, pa_s4[j]});
				if (pa_s4[j] >= afk_pkg::ANG_PI) a0 = a0 - afk_pkg::ANG_2PI_S;
				a1 = a0;
				nf = 1'b0;
				if (a0 > afk_pkg::ANG_HALF_PI_S) begin
					a1 = a0 - afk_pkg::ANG_PI_S;
					nf = 1'b1;
				end else if (a0 < -afk_pkg::ANG_HALF_PI_S) begin
					a1 = a0 + afk_pkg::ANG_PI_S;
					nf = 1'b1;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					pre_q.x   <= afk_pkg::CORDIC_K;
					pre_q.y   <= '0;
					pre_q.z   <= a1;
					pre_q.neg <= nf;
				end
			end
			assign cor[0][j] = pre_q;
		end
	endgenerate

	// CORDIC cell chains, one per angle
	generate
		for (genvar i = 0; i < CS; i++) begin : g_cor
			for (genvar j = 0; j < 4; j++) begin : g_lane
				afk_cordic_cell u_cell (
					.clk   (clk),
					.en    (en),
					.shift (5'(i)),
					.atan  (afk_pkg::atan_q28(5'(i))),
					.din   (cor[i][j]),
					.dout  (cor[i+1][j])
				);
			end
		end
		for (genvar j = 0; j < 4; j++) begin : g_cs
			assign cosv[j] = cor[CS][j].neg ? -cor[CS][j].x : cor[CS][j].x;
			assign sinv[j] = cor[CS][j].neg ? -cor[CS][j].y : cor[CS][j].y;
		end
	endgenerate

	// Segment projections for upper arm, forearm and hand
	generate
		for (genvar k = 0; k < 3; k++) begin : g_seg
			afk_segment u_seg (
				.clk (clk),
				.en  (en),
				.len (len_q[k+1]),
				.cp  (cosv[k+1]),
				.sp  (sinv[k+1]),
				.cy  (cosv[0]),
				.sy  (sinv[0]),
				.tx  (tx[k]),
				.ty  (ty[k]),
				.tz  (tz[k])
			);
		end
	endgenerate

	// Accumulate joint positions
	assign zb = $signed({6'b0, len_q[0]});

	always_ff @(posedge clk) begin
		if (en) begin
			px_s5[0] <= afk_pkg::ACC_W'(tx[0]);
			px_s5[1] <= afk_pkg::ACC_W'(tx[0]) + afk_pkg::ACC_W'(tx[1]);
			px_s5[2] <= afk_pkg::ACC_W'(tx[0]) + afk_pkg::ACC_W'(tx[1]) + afk_pkg::ACC_W'(tx[2]);
			py_s5[0] <= afk_pkg::ACC_W'(ty[0]);
			py_s5[1] <= afk_pkg::ACC_W'(ty[0]) + afk_pkg::ACC_W'(ty[1]);
			py_s5[2] <= afk_pkg::ACC_W'(ty[0]) + afk_pkg::ACC_W'(ty[1]) + afk_pkg::ACC_W'(ty[2]);
			pz_s5[0] <= zb + afk_pkg::ACC_W'(tz[0]);
			pz_s5[1] <= zb + afk_pkg::ACC_W'(tz[0]) + afk_pkg::ACC_W'(tz[1]);
			pz_s5[2] <= zb + afk_pkg::ACC_W'(tz[0]) + afk_pkg::ACC_W'(tz[1])
				+ afk_pkg::ACC_W'(tz[2]);
		end
	end

	// Output register: saturate and hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_tready) begin
			m_valid_q <= vld_q[afk_pkg::ST_ACC];
		end
	end

	always_ff @(posedge clk) begin
		if (!m_valid_q || m_tready) begin
			for (int k = 0; k < 3; k++) begin
				m_data_q[(3*k+0)*afk_pkg::POS_W +: afk_pkg::POS_W] <= afk_pkg::sat_pos(px_s5[k]);
				m_data_q[(3*k+1)*afk_pkg::POS_W +: afk_pkg::POS_W] <= afk_pkg::sat_pos(py_s5[k]);
				m_data_q[(3*k+2)*afk_pkg::POS_W +: afk_pkg::POS_W] <= afk_pkg::sat_pos(pz_s5[k]);
			end
			m_data_q[175:171] <= '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Checks
	assign ang_in_range = ang[0] < afk_pkg::ANG_2PI && ang[1] < afk_pkg::ANG_2PI
		&& ang[2] < afk_pkg::ANG_2PI && ang[3] < afk_pkg::ANG_2PI;
	assign seed_in_range = cor[0][0].z <= afk_pkg::ANG_HALF_PI_S
		&& cor[0][0].z >= -afk_pkg::ANG_HALF_PI_S;

	`AFK_ASSERT_IMPL(a_mod_range, vld_q[afk_pkg::ST_MOD_LAST], ang_in_range, "angle out of range")
	`AFK_ASSERT_IMPL(a_pre_range, vld_q[afk_pkg::ST_PRE], seed_in_range, "seed angle out of range")
	`AFK_ASSERT_IMPL(a_free_out, !m_valid_q, s_tready, "input stalled with empty output register")
	`AFK_ASSERT_NEXT(a_enter, s_tvalid && s_tready, vld_q[afk_pkg::ST_ENC], "pose not tracked")

endmodule
`default_nettype wire

// ===== tb/tb_arm_forward_kinematics.sv =====
// Testbench for arm_forward_kinematics: streams poses through the pipeline under random
// back-pressure and compares every output pose with a fixed-point predictor.
// Depends on afk_pkg and the arm_forward_kinematics RTL.
`timescale 1ns / 100ps
`default_nettype none

// Expected poses and the fixed-point kinematics that produce them
class pose_scoreboard;
	localparam longint TWO_PI  = 1686629713;
	localparam longint PI      = 843314857;
	localparam longint HALF_PI = 421657428;
	localparam longint GAIN_K  = 652032874;

	logic [63:0] angle_map[4];
	longint      seg_len[4];
	logic [8:0][18:0] pose_q[$];
	int          errors;
	string       field_name[9] = '{"elbow_pos_x", "elbow_pos_y", "elbow_pos_z",
		"wrist_pos_x", "wrist_pos_y", "wrist_pos_z", "tip_pos_x", "tip_pos_y", "tip_pos_z"};
	longint      atan_tbl[32] = '{210828714, 124459457, 65760959, 33381290, 16755422,
		8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384,
		8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

	function new();
		for (int i = 0; i < 4; i++) begin
			angle_map[i] = '0;
			seg_len[i] = 0;
		end
		errors = 0;
	endfunction

	function void write_reg(afk_pkg::cfg_idx_t idx, logic [63:0] val);
		if (idx < afk_pkg::CFG_BASE_HEIGHT) angle_map[idx] = val;
		else seg_len[idx - afk_pkg::CFG_BASE_HEIGHT] = longint'(val[15:0]);
	endfunction

	function longint wrap(longint a);
		longint r;
		r = a % TWO_PI;
		if (r < 0) r += TWO_PI;
		return r;
	endfunction

	function longint joint_angle(logic [63:0] map, logic signed [23:0] cnt);
		logic signed [31:0] g;
		logic signed [31:0] o;
		g = map[63:32];
		o = map[31:0];
		return wrap(longint'(cnt) * longint'(g) + longint'(o));
	endfunction

	// Rotate the pre-scaled unit vector by ang; fold into the right half plane first
	function void rotate(longint ang, output longint c, output longint s);
		longint a, x, y, dx, dy;
		bit     neg;
		a = ang;
		x = GAIN_K;
		y = 0;
		neg = 0;
		if (a >= PI) a -= TWO_PI;
		if (a > HALF_PI) begin
			a -= PI;
			neg = 1;
		end else if (a < -HALF_PI) begin
			a += PI;
			neg = 1;
		end
		for (int i = 0; i < afk_pkg::CORDIC_STAGES && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (a >= 0) begin
				x -= dx;
				y += dy;
				a -= atan_tbl[i];
			end else begin
				x += dx;
				y -= dy;
				a += atan_tbl[i];
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function logic [18:0] clamp(longint v);
		if (v > 262143) v = 262143;
		if (v < -262144) v = -262144;
		return v[18:0];
	endfunction

	// Compute the pose for one accepted set of encoder counts and queue it
	function void note_input(logic [3:0][23:0] enc);
		longint ang[4];
		longint cy, sy, cp, sp, h, pitch;
		longint pos[3];
		logic [8:0][18:0] pose;
		for (int i = 0; i < 4; i++) ang[i] = joint_angle(angle_map[i], enc[i]);
		rotate(ang[0], cy, sy);
		pos[0] = 0;
		pos[1] = 0;
		pos[2] = seg_len[0];
		pitch = 0;
		for (int k = 0; k < 3; k++) begin
			pitch = wrap(pitch + ang[k+1]);
			rotate(pitch, cp, sp);
			h = (seg_len[k+1] * cp) >>> 16;
			pos[0] += (h * cy + (64'sd1 <<< 43)) >>> 44;
			pos[1] += (-(h * sy) + (64'sd1 <<< 43)) >>> 44;
			pos[2] += (seg_len[k+1] * sp + (64'sd1 <<< 29)) >>> 30;
			for (int j = 0; j < 3; j++) pose[k*3+j] = clamp(pos[j]);
		end
		pose_q = {pose_q, pose};
	endfunction

	function void check_pose(logic [8:0][18:0] got);
		logic [8:0][18:0] want;
		if (pose_q.size() == 0) begin
			$error("output pose with nothing pending: %h", got);
			errors++;
			return;
		end
		want = pose_q.pop_front();
		for (int i = 0; i < 9; i++)
			if (got[i] !== want[i]) begin
				$error("%s: expected %0d, got %0d", field_name[i],
					$signed(want[i]), $signed(got[i]));
				errors++;
			end
	endfunction
endclass

module tb_arm_forward_kinematics;

	localparam int CYCLE_LIMIT = 400000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [95:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [175:0] m_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_addr;
	logic [63:0]  cfg_wdata;

	pose_scoreboard poses = new();
	bit  no_idle;
	bit  hold_req;
	int  cycles;

	arm_forward_kinematics i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Abort on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Check every output transfer
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) poses.check_pose(m_tdata[170:0]);

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) n = 400;
			else if (no_idle) n = 0;
			else n = $urandom_range(0, 11);
			if (hold_req) hold_req = 0;
			if (n > 0) begin
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Write all eight registers; only called while the pipeline is empty
	task automatic configure(logic [63:0] maps[4], logic [15:0] lens[4]);
		afk_pkg::cfg_idx_t idx;
		for (int i = 0; i < 8; i++) begin
			idx = afk_pkg::cfg_idx_t'(i);
			cfg_we <= 1;
			cfg_addr <= idx;
			cfg_wdata <= (i < 4) ? maps[i] : 64'(lens[i-4]);
			poses.write_reg(idx, (i < 4) ? maps[i] : 64'(lens[i-4]));
			@(posedge clk);
		end
		cfg_we <= 0;
	endtask

	// Offer one pose and hold it until the transfer
	task automatic send_pose(logic [3:0][23:0] enc);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= enc;
		do @(posedge clk); while (!s_tready);
		poses.note_input(enc);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (poses.pose_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_all(logic [23:0] v);
		send_pose({v, v, v, v});
	endtask

	initial begin
		logic [63:0] maps[4];
		logic [15:0] lens[4];
		logic [3:0][23:0] enc;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_we = 0;
		cfg_addr = afk_pkg::CFG_BASE_MAP;
		cfg_wdata = '0;
		no_idle = 0;
		hold_req = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset configuration: every angle zero, every length zero
		send_all(24'h000000);
		send_all(24'h7fffff);
		drain();

		// Realistic arm: about 2pi per 4096 counts
		for (int i = 0; i < 4; i++) maps[i] = {32'd411775, 32'd0};
		lens = '{16'd1600, 16'd4000, 16'd3500, 16'd1200};
		configure(maps, lens);
		send_all(24'h000000);
		send_all(24'h7fffff);
		send_all(24'h800000);
		send_all(24'hffffff);
		send_pose({24'd1024, 24'd1024, -24'sd1024, 24'd512});
		send_pose({24'd2048, 24'd3072, 24'd1024, 24'd2048});
		drain();

		// Angles straddling the quadrant fold at +-pi/2 and pi
		maps = '{{32'd1, 32'd421657428}, {32'd1, -32'sd421657428},
			{32'd1, 32'd843314857}, {32'd1, 32'd0}};
		lens = '{16'd0, 16'd8000, 16'd8000, 16'd8000};
		configure(maps, lens);
		send_all(24'h000000);
		send_all(24'h000001);
		send_all(24'hffffff);
		send_all(24'h7fffff);
		drain();

		// Extreme gains, offsets and lengths
		maps = '{{32'h7fffffff, 32'h7fffffff}, {32'h80000000, 32'h80000000},
			{32'h7fffffff, 32'h80000000}, {32'hffffffff, 32'hffffffff}};
		lens = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
		configure(maps, lens);
		send_all(24'h7fffff);
		send_all(24'h800000);
		send_pose({24'h800000, 24'h7fffff, 24'h000000, 24'h555555});
		send_pose({24'haaaaaa, 24'h000001, 24'hffffff, 24'h7fffff});
		drain();

		// Random phases with random configurations
		for (int ph = 0; ph < 6; ph++) begin
			for (int i = 0; i < 4; i++) begin
				maps[i][31:0] = $urandom;
				maps[i][63:32] = ($urandom_range(0, 3) == 0) ? $urandom
					: 32'($signed($urandom_range(0, 2000000)) - 1000000);
			end
			for (int i = 0; i < 4; i++) lens[i] = 16'($urandom);
			configure(maps, lens);
			no_idle = (ph == 3);
			if (ph == 1) hold_req = 1;
			for (int n = 0; n < 100; n++) begin
				if (ph == 1 && n < 80) no_idle = 1;
				else if (ph != 3) no_idle = 0;
				for (int j = 0; j < 4; j++) enc[j] = 24'($urandom);
				if ($urandom_range(0, 4) == 0)
					enc[$urandom_range(0, 3)] = 24'($urandom_range(0, 4096));
				send_pose(enc);
				if (ph == 4 && n == 50) drain();
			end
			drain();
		end
		no_idle = 0;

		repeat (80) @(posedge clk);
		if (poses.errors == 0 && poses.pose_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== arm_forward_kinematics.f =====
+incdir+hdl
hdl/afk_pkg.sv
hdl/afk_mod_cell.sv
hdl/afk_cordic_cell.sv
hdl/afk_segment.sv
hdl/arm_forward_kinematics.sv
tb/tb_arm_forward_kinematics.sv
